// ===== hdl/mefd_pkg.sv =====
// Shared types, constants and codes for the Manchester edge-interval frame decoder.
package mefd_pkg;

  localparam int INTERVAL_BITS_DEF = 20;
  localparam int THR_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int QUEUE_DEPTH       = 4;
  localparam int WORD_W            = 32;
  localparam int BITS_W            = 6;
  localparam int MSG_SHIFT         = 28;
  localparam int MSG_W             = 3;

  localparam logic [BITS_W-1:0] FRAME_DONE_BITS = 6'd33;
  localparam logic [MSG_W-1:0]  MASTER_MAX_TYPE = 3'd3;

  localparam logic [THR_W-1:0] SPURIOUS_RST = 16'd300;
  localparam logic [THR_W-1:0] ONE_MIN_RST  = 16'd850;
  localparam logic [THR_W-1:0] HALF_MIN_RST = 16'd1250;
  localparam logic [THR_W-1:0] TWO_MIN_RST  = 16'd1760;
  localparam logic [THR_W-1:0] LONG_RST     = 16'd2350;
  localparam int               IDLE_GAP_RST = 20000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPURIOUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP = 3'd5;

  // interval class, as measured against the period thresholds
  typedef enum logic [2:0] {
    CLS_SHORT,
    CLS_ONE,
    CLS_ONE_HALF,
    CLS_TWO,
    CLS_LONG
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LONG     = 3'd2,
    ST_BAD_TWO  = 3'd3,
    ST_PARITY   = 3'd4
  } status_t;

  // classified interval handed from front to back
  typedef struct packed {
    logic arm;    // interval exceeds the idle gap
    cls_t cls;
  } edge_ev_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   frame_word;
    logic [MSG_W-1:0]    msg_type;
    logic [7:0]          data_id;
    logic [15:0]         data_value;
    logic                is_master;
    logic [WORD_W-1:0]   good_frames;
  } result_t;

endpackage

// ===== hdl/mefd_if.sv =====
// Channel interfaces: edge interval requests in, decoded frame/status requests out.
interface mefd_edge_if #(
  parameter int INTERVAL_BITS = mefd_pkg::INTERVAL_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [INTERVAL_BITS-1:0] delta_us;

  modport source (output valid, output delta_us, input ready);
  modport sink   (input valid, input delta_us, output ready);
endinterface

interface mefd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] frame_word;
  logic [2:0]  msg_type;
  logic [7:0]  data_id;
  logic [15:0] data_value;
  logic        is_master;
  logic [31:0] good_frames;

  modport source (output valid, output status, output frame_word, output msg_type,
                  output data_id, output data_value, output is_master,
                  output good_frames, input ready);
  modport sink   (input valid, input status, input frame_word, input msg_type,
                  input data_id, input data_value, input is_master,
                  input good_frames, output ready);
endinterface

// ===== hdl/mefd_front.sv =====
// Front end: sums edge time past the spurious limit and classifies each interval.
module mefd_front #(
  parameter int INTERVAL_BITS = mefd_pkg::INTERVAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mefd_edge_if.sink                           in_edge,
  input  logic [mefd_pkg::THR_W-1:0]          spurious_limit,
  input  logic [mefd_pkg::THR_W-1:0]          one_min,
  input  logic [mefd_pkg::THR_W-1:0]          half_min,
  input  logic [mefd_pkg::THR_W-1:0]          two_min,
  input  logic [mefd_pkg::THR_W-1:0]          too_long,
  input  logic [INTERVAL_BITS-1:0]            idle_gap,
  output logic                                push,
  output mefd_pkg::edge_ev_t                  push_ev,
  input  logic                                q_ready
);

  logic [INTERVAL_BITS-1:0] acc_r, acc_nxt;
  logic [INTERVAL_BITS:0]   sum;
  logic [INTERVAL_BITS-1:0] iv;
  logic                     accept;
  logic                     real_edge;

  assign in_edge.ready = q_ready;
  assign accept        = in_edge.valid && q_ready;

  always_comb begin
    sum       = {1'b0, acc_r} + {1'b0, in_edge.delta_us};
    iv        = sum[INTERVAL_BITS] ? {INTERVAL_BITS{1'b1}} : sum[INTERVAL_BITS-1:0];
    real_edge = iv > INTERVAL_BITS'(spurious_limit);
    acc_nxt   = acc_r;
    if (accept) begin
      acc_nxt = real_edge ? '0 : iv;
    end

    // priority: too long, two, one and a half, one, else too short
    push_ev.arm = iv > idle_gap;
    if (iv >= INTERVAL_BITS'(too_long)) begin
      push_ev.cls = mefd_pkg::CLS_LONG;
    end else if (iv >= INTERVAL_BITS'(two_min)) begin
      push_ev.cls = mefd_pkg::CLS_TWO;
    end else if (iv >= INTERVAL_BITS'(half_min)) begin
      push_ev.cls = mefd_pkg::CLS_ONE_HALF;
    end else if (iv >= INTERVAL_BITS'(one_min)) begin
      push_ev.cls = mefd_pkg::CLS_ONE;
    end else begin
      push_ev.cls = mefd_pkg::CLS_SHORT;
    end
  end

  assign push = accept && real_edge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== hdl/mefd_queue.sv =====
// Small register queue of classified intervals between front and back end.
module mefd_queue #(
  parameter int DEPTH = mefd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mefd_pkg::edge_ev_t push_ev,
  output logic               push_ready,
  output logic               pop_valid,
  output mefd_pkg::edge_ev_t pop_ev,
  input  logic               pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mefd_pkg::edge_ev_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_ev     = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_ev;
    end
  end

endmodule

// ===== hdl/mefd_back.sv =====
// Back end: bit assembly, parity and frame reporting, with the output register.
module mefd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  input  mefd_pkg::edge_ev_t ev,
  output logic               ev_pop,
  mefd_result_if.source      out_res
);

  logic                                 receiving_r, receiving_nxt;
  logic                                 last_bit_r, last_bit_nxt;
  logic [mefd_pkg::WORD_W-1:0]          shift_r, shift_nxt;
  logic [mefd_pkg::BITS_W-1:0]          bits_r, bits_nxt;
  logic                                 odd_r, odd_nxt;
  logic [mefd_pkg::WORD_W-1:0]          total_r, total_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  mefd_pkg::result_t                    res_r, res_nxt;
  logic                                 slot_free;
  logic                                 emit;
  logic                                 decoded;
  mefd_pkg::status_t                    st;
  logic [mefd_pkg::WORD_W-1:0]          word;
  logic [mefd_pkg::MSG_W-1:0]           mt;

  assign slot_free = !out_valid_r || out_res.ready;
  assign ev_pop    = ev_valid && slot_free;

  always_comb begin
    receiving_nxt = receiving_r;
    last_bit_nxt  = last_bit_r;
    shift_nxt     = shift_r;
    bits_nxt      = bits_r;
    odd_nxt       = odd_r;
    total_nxt     = total_r;
    emit          = 1'b0;
    decoded       = 1'b0;
    st            = mefd_pkg::ST_OK;

    if (ev_pop) begin
      if (!receiving_r) begin
        if (ev.arm) begin
          receiving_nxt = 1'b1;
          shift_nxt     = '0;
          odd_nxt       = 1'b0;
          bits_nxt      = mefd_pkg::BITS_W'(1);
          last_bit_nxt  = 1'b1;
        end
      end else begin
        case (ev.cls)
          mefd_pkg::CLS_LONG: begin
            emit = 1'b1;
            st   = mefd_pkg::ST_LONG;
          end
          mefd_pkg::CLS_TWO: begin
            if (last_bit_r) begin
              emit = 1'b1;
              st   = mefd_pkg::ST_BAD_TWO;
            end else begin
              shift_nxt    = {shift_r[mefd_pkg::WORD_W-3:0], 2'b10};
              bits_nxt     = bits_r + 2'd2;
              odd_nxt      = !odd_r;
              last_bit_nxt = 1'b0;
            end
          end
          mefd_pkg::CLS_ONE_HALF: begin
            if (last_bit_r) begin
              shift_nxt    = {shift_r[mefd_pkg::WORD_W-3:0], 2'b10};
              bits_nxt     = bits_r + 2'd2;
              last_bit_nxt = 1'b0;
            end else begin
              shift_nxt    = {shift_r[mefd_pkg::WORD_W-2:0], 1'b1};
              bits_nxt     = bits_r + 1'b1;
              last_bit_nxt = 1'b1;
            end
            odd_nxt = !odd_r;
          end
          mefd_pkg::CLS_ONE: begin
            shift_nxt = {shift_r[mefd_pkg::WORD_W-2:0], last_bit_r};
            bits_nxt  = bits_r + 1'b1;
            odd_nxt   = odd_r ^ last_bit_r;
          end
          default: begin
            emit = 1'b1;
            st   = mefd_pkg::ST_SHORT;
          end
        endcase

        if (emit) begin
          receiving_nxt = 1'b0;
        end else if (bits_nxt > mefd_pkg::FRAME_DONE_BITS) begin
          receiving_nxt = 1'b0;
          emit          = 1'b1;
          decoded       = 1'b1;
          if (odd_nxt) begin
            total_nxt = total_r + 1'b1;
            st        = mefd_pkg::ST_OK;
          end else begin
            st        = mefd_pkg::ST_PARITY;
          end
        end
      end
    end

    word = decoded ? shift_nxt : '0;
    mt   = word[mefd_pkg::MSG_SHIFT +: mefd_pkg::MSG_W];
    res_nxt.status      = st;
    res_nxt.frame_word  = word;
    res_nxt.msg_type    = mt;
    res_nxt.data_id     = word[23:16];
    res_nxt.data_value  = word[15:0];
    res_nxt.is_master   = decoded && (mt <= mefd_pkg::MASTER_MAX_TYPE);
    res_nxt.good_frames = total_nxt;

    out_valid_nxt = out_valid_r;
    if (ev_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      last_bit_r  <= 1'b1;
      shift_r     <= '0;
      bits_r      <= '0;
      odd_r       <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      receiving_r <= receiving_nxt;
      last_bit_r  <= last_bit_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      odd_r       <= odd_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = res_r.status;
  assign out_res.frame_word  = res_r.frame_word;
  assign out_res.msg_type    = res_r.msg_type;
  assign out_res.data_id     = res_r.data_id;
  assign out_res.data_value  = res_r.data_value;
  assign out_res.is_master   = res_r.is_master;
  assign out_res.good_frames = res_r.good_frames;

  // a frame in progress never holds more than the completion count
  assert property (@(posedge clk) disable iff (!rst_n)
    receiving_r |-> (bits_r <= mefd_pkg::FRAME_DONE_BITS))
    else $error("bit count past frame length while receiving");

  // good frame count only moves with a reported good frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != $past(total_r)) |->
      ($past(ev_pop && emit) && res_r.status == mefd_pkg::ST_OK && out_valid_r))
    else $error("good frame count changed without a good frame");

  // receive errors carry an empty frame word
  assert property (@(posedge clk) disable iff (!rst_n)
    (ev_pop && emit && (st == mefd_pkg::ST_SHORT || st == mefd_pkg::ST_LONG ||
                        st == mefd_pkg::ST_BAD_TWO))
      |=> (res_r.frame_word == '0 && !res_r.is_master))
    else $error("error status with nonzero frame fields");

endmodule

// ===== hdl/manchester_edge_interval_frame_decoder_unit.sv =====
// Manchester edge-interval frame decoder: configuration registers and top-level wiring.
//
// in_edge carries one falling-edge request per item: delta_us, the microseconds
// since the previous raw edge. out_res carries one status request per reported
// frame or receive error: status, frame word, decoded fields and the running
// good-frame count. Both channels use valid/ready; a request moves when both
// are high at a rising clock edge.
// Throughput: one edge per cycle while the queue has room. Each edge is classified
// in the cycle it is accepted and queued; the back end takes one queued edge per cycle
// while out_res is not stalled. With the queue empty, the edge that causes a result is
// written into a queue entry when accepted, and the result is then captured in the
// output register, which drives out_res.valid.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle (unchecked); indexes beyond the register list are dropped.
// Reset (rst_n low, synchronous) loads the default thresholds, empties the
// queue and output register and leaves the receiver disarmed.
// When out_res stalls, the back end holds its result and stops; the four-entry
// queue keeps accepting edges until it fills, then in_edge.ready drops.
module manchester_edge_interval_frame_decoder_unit #(
  parameter int INTERVAL_BITS = mefd_pkg::INTERVAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mefd_edge_if.sink                         in_edge,
  mefd_result_if.source                     out_res,
  input  logic                              cfg_we,
  input  logic [mefd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [INTERVAL_BITS-1:0]          cfg_data
);

  logic [mefd_pkg::THR_W-1:0] spurious_r, one_min_r, half_min_r, two_min_r, long_r;
  logic [INTERVAL_BITS-1:0]   idle_gap_r;

  logic               push, push_ready;
  mefd_pkg::edge_ev_t push_ev, pop_ev;
  logic               pop_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spurious_r <= mefd_pkg::SPURIOUS_RST;
      one_min_r  <= mefd_pkg::ONE_MIN_RST;
      half_min_r <= mefd_pkg::HALF_MIN_RST;
      two_min_r  <= mefd_pkg::TWO_MIN_RST;
      long_r     <= mefd_pkg::LONG_RST;
      idle_gap_r <= INTERVAL_BITS'(mefd_pkg::IDLE_GAP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        mefd_pkg::CFG_SPURIOUS: spurious_r <= cfg_data[mefd_pkg::THR_W-1:0];
        mefd_pkg::CFG_ONE_MIN:  one_min_r  <= cfg_data[mefd_pkg::THR_W-1:0];
        mefd_pkg::CFG_HALF_MIN: half_min_r <= cfg_data[mefd_pkg::THR_W-1:0];
        mefd_pkg::CFG_TWO_MIN:  two_min_r  <= cfg_data[mefd_pkg::THR_W-1:0];
        mefd_pkg::CFG_LONG:     long_r     <= cfg_data[mefd_pkg::THR_W-1:0];
        mefd_pkg::CFG_IDLE_GAP: idle_gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mefd_front #(
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_edge        (in_edge),
    .spurious_limit (spurious_r),
    .one_min        (one_min_r),
    .half_min       (half_min_r),
    .two_min        (two_min_r),
    .too_long       (long_r),
    .idle_gap       (idle_gap_r),
    .push           (push),
    .push_ev        (push_ev),
    .q_ready        (push_ready)
  );

  mefd_queue #(
    .DEPTH(mefd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ev    (push_ev),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ev     (pop_ev),
    .pop        (pop)
  );

  mefd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (pop_valid),
    .ev       (pop_ev),
    .ev_pop   (pop),
    .out_res  (out_res)
  );

endmodule

// ===== dv/mefd_frame_checker.sv =====
// Checker: predicts decoder status requests from observed edges and compares them.
module mefd_frame_checker #(
  parameter int INTERVAL_BITS = mefd_pkg::INTERVAL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mefd_edge_if                           edge_mon,
  mefd_result_if                         res_mon,
  input  logic                           cfg_we,
  input  logic [mefd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [INTERVAL_BITS-1:0]       cfg_data,
  output int                             fail_count,
  output int                             due_count,
  output int                             results_seen,
  output int                             good_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IB = INTERVAL_BITS;

  // register copies
  logic [mefd_pkg::THR_W-1:0] spur, one_min, half_min, two_min, long_lim;
  logic [IB-1:0]              idle_gap;

  // decoder state copy
  logic [IB-1:0]               elapsed;
  bit                          armed;
  bit                          prev_bit;
  logic [mefd_pkg::WORD_W-1:0] word;
  logic [mefd_pkg::BITS_W-1:0] nbits;
  bit                          parity;
  logic [mefd_pkg::WORD_W-1:0] good_count;

  mefd_pkg::result_t frames_due[$];
  int                fails;
  int                nres;
  int                ngood;

  function automatic mefd_pkg::cls_t classify(input logic [IB-1:0] iv);
    // priority order matters when thresholds are misordered
    if (iv >= long_lim) return mefd_pkg::CLS_LONG;
    if (iv >= two_min) return mefd_pkg::CLS_TWO;
    if (iv >= half_min) return mefd_pkg::CLS_ONE_HALF;
    if (iv >= one_min) return mefd_pkg::CLS_ONE;
    return mefd_pkg::CLS_SHORT;
  endfunction

  function automatic mefd_pkg::result_t make_result(input mefd_pkg::status_t st,
                                                    input logic [mefd_pkg::WORD_W-1:0] w,
                                                    input bit decoded);
    mefd_pkg::result_t r;
    r.status      = st;
    r.frame_word  = w;
    r.msg_type    = w[mefd_pkg::MSG_SHIFT +: mefd_pkg::MSG_W];
    r.data_id     = w[23:16];
    r.data_value  = w[15:0];
    r.is_master   = decoded &&
                    (w[mefd_pkg::MSG_SHIFT +: mefd_pkg::MSG_W] <= mefd_pkg::MASTER_MAX_TYPE);
    r.good_frames = good_count;
    return r;
  endfunction

  function automatic bit decode_edge(input logic [IB-1:0] d, output mefd_pkg::result_t r);
    logic [IB:0]   sum;
    logic [IB-1:0] iv;
    r   = '0;
    sum = {1'b0, elapsed} + {1'b0, d};
    elapsed = sum[IB] ? '1 : sum[IB-1:0];
    if (elapsed <= spur) return 0;
    iv      = elapsed;
    elapsed = '0;
    if (!armed) begin
      if (iv > idle_gap) begin
        armed    = 1;
        word     = '0;
        parity   = 0;
        nbits    = mefd_pkg::BITS_W'(1);
        prev_bit = 1;
      end
      return 0;
    end
    case (classify(iv))
      mefd_pkg::CLS_LONG: begin
        armed = 0;
        r = make_result(mefd_pkg::ST_LONG, '0, 0);
        return 1;
      end
      mefd_pkg::CLS_TWO: begin
        if (prev_bit) begin
          armed = 0;
          r = make_result(mefd_pkg::ST_BAD_TWO, '0, 0);
          return 1;
        end
        word     = {word[mefd_pkg::WORD_W-3:0], 2'b10};
        nbits    = nbits + mefd_pkg::BITS_W'(2);
        parity   = !parity;
        prev_bit = 0;
      end
      mefd_pkg::CLS_ONE_HALF: begin
        if (prev_bit) begin
          word  = {word[mefd_pkg::WORD_W-3:0], 2'b10};
          nbits = nbits + mefd_pkg::BITS_W'(2);
        end else begin
          word  = {word[mefd_pkg::WORD_W-2:0], 1'b1};
          nbits = nbits + mefd_pkg::BITS_W'(1);
        end
        parity   = !parity;
        prev_bit = !prev_bit;
      end
      mefd_pkg::CLS_ONE: begin
        word   = {word[mefd_pkg::WORD_W-2:0], prev_bit};
        nbits  = nbits + mefd_pkg::BITS_W'(1);
        parity = parity ^ prev_bit;
      end
      default: begin
        armed = 0;
        r = make_result(mefd_pkg::ST_SHORT, '0, 0);
        return 1;
      end
    endcase
    if (nbits > mefd_pkg::FRAME_DONE_BITS) begin
      armed = 0;
      if (parity) begin
        good_count = good_count + 1'b1;
        r = make_result(mefd_pkg::ST_OK, word, 1);
      end else begin
        r = make_result(mefd_pkg::ST_PARITY, word, 1);
      end
      return 1;
    end
    return 0;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] e,
                                    input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    fails = 0;
    nres  = 0;
    ngood = 0;
  end

  always @(posedge clk) begin : watch
    mefd_pkg::result_t want;
    int                bad;
    if (!rst_n) begin
      spur       = mefd_pkg::SPURIOUS_RST;
      one_min    = mefd_pkg::ONE_MIN_RST;
      half_min   = mefd_pkg::HALF_MIN_RST;
      two_min    = mefd_pkg::TWO_MIN_RST;
      long_lim   = mefd_pkg::LONG_RST;
      idle_gap   = IB'(mefd_pkg::IDLE_GAP_RST);
      elapsed    = '0;
      armed      = 0;
      prev_bit   = 1;
      word       = '0;
      nbits      = '0;
      parity     = 0;
      good_count = '0;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mefd_pkg::CFG_SPURIOUS: spur     = cfg_data[mefd_pkg::THR_W-1:0];
          mefd_pkg::CFG_ONE_MIN:  one_min  = cfg_data[mefd_pkg::THR_W-1:0];
          mefd_pkg::CFG_HALF_MIN: half_min = cfg_data[mefd_pkg::THR_W-1:0];
          mefd_pkg::CFG_TWO_MIN:  two_min  = cfg_data[mefd_pkg::THR_W-1:0];
          mefd_pkg::CFG_LONG:     long_lim = cfg_data[mefd_pkg::THR_W-1:0];
          mefd_pkg::CFG_IDLE_GAP: idle_gap = cfg_data;
          default: ;
        endcase
      end
      if (edge_mon.valid && edge_mon.ready) begin
        if (decode_edge(edge_mon.delta_us, want)) frames_due.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        nres++;
        if (res_mon.status == mefd_pkg::ST_OK) ngood++;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d word %h",
                   $time, res_mon.status, res_mon.frame_word);
          fails++;
        end else begin
          want = frames_due.pop_front();
          bad  = field_diff("status", 32'(want.status), 32'(res_mon.status))
               + field_diff("frame_word", want.frame_word, res_mon.frame_word)
               + field_diff("msg_type", 32'(want.msg_type), 32'(res_mon.msg_type))
               + field_diff("data_id", 32'(want.data_id), 32'(res_mon.data_id))
               + field_diff("data_value", 32'(want.data_value), 32'(res_mon.data_value))
               + field_diff("is_master", 32'(want.is_master), 32'(res_mon.is_master))
               + field_diff("good_frames", want.good_frames, res_mon.good_frames);
          if (bad != 0) fails++;
        end
      end
    end
    due_count    <= frames_due.size();
    fail_count   <= fails;
    results_seen <= nres;
    good_seen    <= ngood;
  end

endmodule

// ===== dv/manchester_edge_interval_frame_decoder_unit_test.sv =====
// Testbench top: clock, reset, edge and register stimulus, result drain and verdict.
module manchester_edge_interval_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IB          = mefd_pkg::INTERVAL_BITS_DEF;
  localparam int DELTA_MAX   = (1 << IB) - 1;
  localparam int ITEMS_TOTAL = 1950;
  localparam int SETTLE_CYC  = 10;
  localparam int HOLD_CYC    = 400;
  localparam int LIMIT_NS    = 4_000_000;
  localparam int DONE_BITS   = int'(mefd_pkg::FRAME_DONE_BITS);

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mefd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [IB-1:0]                  cfg_data;

  int fail_count, due_count, results_seen, good_seen;

  mefd_edge_if #(.INTERVAL_BITS(IB)) edge_ch ();
  mefd_result_if res_ch ();

  manchester_edge_interval_frame_decoder_unit #(.INTERVAL_BITS(IB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_edge   (edge_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mefd_frame_checker #(.INTERVAL_BITS(IB)) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .edge_mon     (edge_ch),
    .res_mon      (res_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .due_count    (due_count),
    .results_seen (results_seen),
    .good_seen    (good_seen)
  );

  // generator's view of the thresholds
  int sp, p1, p15, p2, pl, gap;
  int edges_sent;
  int cfg_sets;
  bit in_burst;
  bit out_burst;
  bit dirty;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout", $time);
    $display("manchester_edge_interval_frame_decoder_unit_test: FAIL");
    $finish;
  end

  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return int'($urandom_range(hi, lo));
  endfunction

  task automatic send_edge(input int d);
    int idle_cyc;
    if (edges_sent % 64 == 0) in_burst = ($urandom_range(3, 0) == 0);
    idle_cyc = in_burst ? 0 : pick(0, 11);
    if (idle_cyc > 0) begin
      edge_ch.valid <= 1'b0;
      repeat (idle_cyc) @(posedge clk);
    end
    edge_ch.valid    <= 1'b1;
    edge_ch.delta_us <= IB'(d);
    @(posedge clk);
    while (!edge_ch.ready) @(posedge clk);
    edges_sent++;
  endtask

  // wait until no result is due and the pipeline has drained
  task automatic settle();
    edge_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mefd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [IB-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic apply_config(input int s, input int a, input int b, input int c,
                              input int l, input int g);
    settle();
    // upper bits of the 16-bit registers carry junk that must be dropped
    write_reg(mefd_pkg::CFG_SPURIOUS, {4'($urandom), 16'(s)});
    write_reg(mefd_pkg::CFG_ONE_MIN, {4'($urandom), 16'(a)});
    write_reg(mefd_pkg::CFG_HALF_MIN, {4'($urandom), 16'(b)});
    write_reg(mefd_pkg::CFG_TWO_MIN, {4'($urandom), 16'(c)});
    write_reg(mefd_pkg::CFG_LONG, {4'($urandom), 16'(l)});
    write_reg(mefd_pkg::CFG_IDLE_GAP, IB'(g));
    write_reg(mefd_pkg::CFG_IDLE_GAP + mefd_pkg::CFG_IDX_W'(pick(1, 2)), IB'($urandom));
    cfg_we <= 1'b0;
    sp = s; p1 = a; p15 = b; p2 = c; pl = l; gap = g;
    cfg_sets++;
  endtask

  function automatic int class_delta(input mefd_pkg::cls_t c);
    case (c)
      mefd_pkg::CLS_SHORT:    return pick(sp + 1, p1 - 1);
      mefd_pkg::CLS_ONE:      return pick(p1, p15 - 1);
      mefd_pkg::CLS_ONE_HALF: return pick(p15, p2 - 1);
      mefd_pkg::CLS_TWO:      return pick(p2, pl - 1);
      default:      return $urandom_range(1, 0) ? pick(pl, pl + 500) : pick(pl, DELTA_MAX);
    endcase
  endfunction

  // interval of a given class, sometimes split by a spurious glitch
  task automatic send_class(input mefd_pkg::cls_t c);
    int d;
    int p;
    d = class_delta(c);
    if (sp > 0 && $urandom_range(7, 0) == 0) begin
      p = pick(0, sp);
      send_edge(p);
      send_edge(d - p);
    end else begin
      send_edge(d);
    end
  endtask

  task automatic send_frame();
    int             nb;
    int             err_at;
    int             r;
    bit             lb;
    mefd_pkg::cls_t c;
    // a short interval leaves the receiver disarmed from any state
    if (dirty) begin
      send_class(mefd_pkg::CLS_SHORT);
      dirty = 0;
    end
    send_edge($urandom_range(1, 0) ? pick(gap + 1, (gap + 2000 < DELTA_MAX) ?
                                          gap + 2000 : DELTA_MAX)
                                   : pick(gap + 1, DELTA_MAX));
    nb     = 1;
    lb     = 1;
    err_at = ($urandom_range(5, 0) == 0) ? pick(2, DONE_BITS) : 0;
    while (nb <= DONE_BITS) begin
      if (err_at != 0 && nb >= err_at) begin
        r = pick(0, 2);
        c = (r == 0) ? mefd_pkg::CLS_SHORT :
            (r == 1 || !lb) ? mefd_pkg::CLS_LONG : mefd_pkg::CLS_TWO;
        send_class(c);
        return;
      end
      if (lb) begin
        c = $urandom_range(1, 0) ? mefd_pkg::CLS_ONE : mefd_pkg::CLS_ONE_HALF;
      end else begin
        r = pick(0, 2);
        c = (r == 0) ? mefd_pkg::CLS_ONE :
            (r == 1) ? mefd_pkg::CLS_ONE_HALF : mefd_pkg::CLS_TWO;
      end
      send_class(c);
      if (c == mefd_pkg::CLS_ONE) begin
        nb += 1;
      end else if (c == mefd_pkg::CLS_TWO || lb) begin
        nb += 2;
        lb = 0;
      end else begin
        nb += 1;
        lb = 1;
      end
    end
  endtask

  task automatic send_noise(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = pick(0, 2);
      if (r == 0) send_edge(int'($urandom) & DELTA_MAX);
      else if (r == 1) send_edge(pick(0, 3000));
      else send_edge(pick(0, 70000));
    end
    // end on a real edge so the accumulator is clear
    send_edge(pick(sp + 1, DELTA_MAX));
    dirty = 1;
  endtask

  task automatic run_phase(input bit framable, input int budget);
    int target;
    target = edges_sent + budget;
    if (target > ITEMS_TOTAL) target = ITEMS_TOTAL;
    while (edges_sent < target) begin
      if (framable && $urandom_range(6, 0) != 0) send_frame();
      else send_noise(pick(1, 6));
    end
  endtask

  task automatic ordered_config();
    int s, a, b, c, l;
    s = ($urandom_range(3, 0) == 0) ? 0 : pick(0, 1500);
    a = s + 2 + pick(0, 1500);
    b = a + 1 + pick(0, 1500);
    c = b + 1 + pick(0, 1500);
    l = c + 1 + pick(0, 2000);
    apply_config(s, a, b, c, l,
                 $urandom_range(1, 0) ? l + pick(0, 30000) : pick(l, DELTA_MAX - 1));
  endtask

  task automatic scrambled_config();
    apply_config(pick(0, 65535), pick(0, 65535), pick(0, 65535), pick(0, 65535),
                 pick(0, 65535), pick(0, 70000));
  endtask

  // receiver: random back-pressure plus one long hold to fill the block
  initial begin : drain
    int w;
    int taken;
    bit held;
    taken     = 0;
    held      = 0;
    out_burst = 0;
    res_ch.ready = 1'b0;
    forever begin
      if (taken % 32 == 0) out_burst = ($urandom_range(3, 0) == 0);
      w = out_burst ? 0 : pick(0, 11);
      if (!held && taken == 20) begin
        w    = HOLD_CYC;
        held = 1;
      end
      if (w > 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stim
    int wait_cyc;
    int fails;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    edge_ch.valid    = 1'b0;
    edge_ch.delta_us = '0;
    edges_sent       = 0;
    cfg_sets         = 0;
    in_burst         = 0;
    dirty            = 0;
    sp = int'(mefd_pkg::SPURIOUS_RST); p1 = int'(mefd_pkg::ONE_MIN_RST);
    p15 = int'(mefd_pkg::HALF_MIN_RST); p2 = int'(mefd_pkg::TWO_MIN_RST);
    pl = int'(mefd_pkg::LONG_RST); gap = mefd_pkg::IDLE_GAP_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset thresholds
    send_edge(20000);      // equal to idle gap: stays disarmed
    send_edge(0);          // glitches below the spurious limit are summed
    send_edge(300);
    send_edge(1);          // sum just over the limit, still idle
    send_edge(20001);      // arms
    send_edge(849);        // too short
    send_edge(200);
    send_edge(DELTA_MAX);  // accumulator saturates, arms
    send_edge(2350);       // too long
    send_edge(DELTA_MAX);
    send_edge(1760);       // two periods right after a one
    send_edge(DELTA_MAX);
    send_edge(1249);
    send_edge(1250);
    send_edge(850);
    send_edge(1759);
    send_edge(1500);
    send_edge(2349);
    send_edge(300);        // spurious piece of the next interval
    send_edge(1900);
    send_edge(2350);
    dirty = 1;

    // tight, wide and scrambled settings, then random ones
    ordered_config();
    run_phase(1, 200);
    apply_config(0, 2, 3, 4, 5, 5);
    run_phase(1, 200);
    apply_config(60000, 61000, 62000, 63000, 65535, DELTA_MAX - 1);
    run_phase(1, 200);
    apply_config(65535, 65535, 0, 65535, 0, 0);
    run_phase(0, 80);
    apply_config(0, 65535, 65535, 0, 65535, DELTA_MAX);
    run_phase(0, 80);
    scrambled_config();
    run_phase(0, 80);
    while (edges_sent < ITEMS_TOTAL) begin
      if ($urandom_range(3, 0) != 0) begin
        ordered_config();
        run_phase(1, 200);
      end else begin
        scrambled_config();
        run_phase(0, 80);
      end
    end

    edge_ch.valid <= 1'b0;
    wait_cyc = 0;
    @(posedge clk);
    while (due_count != 0 && wait_cyc < 5000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (20) @(posedge clk);
    fails = fail_count;
    if (due_count != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_count);
      fails += due_count;
    end
    $display("covered %0d edge requests under %0d register settings", edges_sent, cfg_sets);
    $display("checked %0d result requests, %0d of them good frames", results_seen, good_seen);
    if (fails == 0) begin
      $display("manchester_edge_interval_frame_decoder_unit_test: PASS");
    end else begin
      $display("manchester_edge_interval_frame_decoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule
